// ===== design/mwm_pkg.sv =====
// Mecanum wheel mixer: shared widths, constants and pipeline word types.
// No dependencies; every other file of the block imports this package.
package mwm_pkg;

  localparam int unsigned SpeedW    = 16;  // command and wheel fields
  localparam int unsigned MagW      = 16;  // |speed| up to 32768
  localparam int unsigned SumW      = 17;  // |x|+|y|+|w| up to 98304
  localparam int unsigned ProdW     = 32;  // |combo| * max, below 2^32
  localparam int unsigned QuotW     = 16;  // quotient up to 32768
  localparam int unsigned NumWheels = 4;
  localparam int unsigned DivSteps  = QuotW;

  localparam logic [QuotW-1:0] WheelMax = 16'd32767;

  // one wheel's state inside the divider chain
  typedef struct packed {
    logic            neg;
    logic [SumW-1:0] rem;
    logic [QuotW-1:0] low;  // dividend bits still to consume, quotient bits shift in
  } mwm_lane_t;

  typedef struct packed {
    logic [SumW-1:0]                  divisor;
    mwm_lane_t [NumWheels-1:0]        lane;
  } mwm_word_t;

  // mixed command before scaling
  typedef struct packed {
    logic [MagW-1:0]                  peak;
    logic [SumW-1:0]                  divisor;
    logic [NumWheels-1:0]             neg;
    logic [NumWheels-1:0][SumW-1:0]   mag;
  } mwm_mix_t;

endpackage

// ===== design/mwm_if.sv =====
// Mecanum wheel mixer: valid/ready channel interfaces for commands and wheel speeds.
// Depends on mwm_pkg.
interface mwm_cmd_if;
  import mwm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] strafe_speed;
  logic signed [SpeedW-1:0] forward_speed;
  logic signed [SpeedW-1:0] turn_speed;

  modport source (output valid, strafe_speed, forward_speed, turn_speed, input ready);
  modport sink (input valid, strafe_speed, forward_speed, turn_speed, output ready);
endinterface

interface mwm_wheel_if;
  import mwm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] wheel_one;
  logic signed [SpeedW-1:0] wheel_two;
  logic signed [SpeedW-1:0] wheel_three;
  logic signed [SpeedW-1:0] wheel_four;

  modport source (output valid, wheel_one, wheel_two, wheel_three, wheel_four, input ready);
  modport sink (input valid, wheel_one, wheel_two, wheel_three, wheel_four, output ready);
endinterface

// ===== design/mecanum_wheel_mixer_unit.sv =====
// Mecanum wheel mixer: turns a strafe/forward/turn command into four wheel speeds,
// each (y +- x +- w) * max(|x|,|y|,|w|) / (|x|+|y|+|w|), truncated toward zero and
// clamped to +-32767. A new command is taken every cycle unless backpressure has filled the chain;
// each beat passes through the mixing and scaling-multiply stages of mwm_prep, sixteen cells of a
// restoring divider that each settle one quotient bit for all four wheels at once,
// and the clamp into the output register. Backpressure stalls only the
// stages that hold data. Depends on mwm_pkg, mwm_if, mwm_prep, mwm_div_cell, mwm_out.
module mecanum_wheel_mixer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  mwm_cmd_if.sink     cmd_i,
  mwm_wheel_if.source wheel_o
);
  import mwm_pkg::*;

  logic      chain_valid [DivSteps+1];
  logic      chain_ready [DivSteps+1];
  mwm_word_t chain_word [DivSteps+1];

  mwm_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .strafe_i    (cmd_i.strafe_speed),
    .forward_i   (cmd_i.forward_speed),
    .turn_i      (cmd_i.turn_speed),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_word_o  (chain_word[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    mwm_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[i]),
      .in_ready_o  (chain_ready[i]),
      .in_word_i   (chain_word[i]),
      .out_valid_o (chain_valid[i+1]),
      .out_ready_i (chain_ready[i+1]),
      .out_word_o  (chain_word[i+1])
    );
  end

  mwm_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (chain_valid[DivSteps]),
    .in_ready_o (chain_ready[DivSteps]),
    .in_word_i  (chain_word[DivSteps]),
    .wheel_o    (wheel_o)
  );

endmodule

// ===== design/mwm_prep.sv =====
// Mecanum wheel mixer: magnitudes, peak, sum and wheel mixes, then the scaling
// multiply. Two register stages. Depends on mwm_pkg.
module mwm_prep (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [mwm_pkg::SpeedW-1:0] strafe_i,
  input  logic signed [mwm_pkg::SpeedW-1:0] forward_i,
  input  logic signed [mwm_pkg::SpeedW-1:0] turn_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mwm_pkg::mwm_word_t               out_word_o
);
  import mwm_pkg::*;

  logic signed [SumW:0] x_s, y_s, w_s;
  logic signed [SumW:0] ax_s, ay_s, aw_s;
  logic [MagW-1:0]      ax, ay, aw;
  logic [SumW-1:0]      sum;
  logic signed [SumW:0] combo [NumWheels];
  logic signed [SumW:0] combo_abs [NumWheels];
  mwm_mix_t             mix_d, mix_q;
  logic                 a_valid_q;
  logic                 a_ready, b_ready;
  logic [ProdW-1:0]     prod [NumWheels];
  mwm_word_t            word_d, word_q;
  logic                 b_valid_q;

  assign x_s = {{2{strafe_i[SpeedW-1]}}, strafe_i};
  assign y_s = {{2{forward_i[SpeedW-1]}}, forward_i};
  assign w_s = {{2{turn_i[SpeedW-1]}}, turn_i};

  assign ax_s = x_s[SumW] ? -x_s : x_s;
  assign ay_s = y_s[SumW] ? -y_s : y_s;
  assign aw_s = w_s[SumW] ? -w_s : w_s;
  assign ax = ax_s[MagW-1:0];
  assign ay = ay_s[MagW-1:0];
  assign aw = aw_s[MagW-1:0];
  assign sum = {1'b0, ax} + {1'b0, ay} + {1'b0, aw};

  assign combo[0] = y_s - x_s + w_s;
  assign combo[1] = y_s + x_s - w_s;
  assign combo[2] = y_s - x_s - w_s;
  assign combo[3] = y_s + x_s + w_s;

  always_comb begin
    mix_d = '0;
    mix_d.peak = ay;
    if (ax > mix_d.peak) begin
      mix_d.peak = ax;
    end
    if (aw > mix_d.peak) begin
      mix_d.peak = aw;
    end
    mix_d.divisor = (sum == '0) ? SumW'(1) : sum;
    for (int k = 0; k < NumWheels; k++) begin
      combo_abs[k]  = combo[k][SumW] ? -combo[k] : combo[k];
      mix_d.neg[k]  = combo[k][SumW];
      mix_d.mag[k]  = combo_abs[k][SumW-1:0];
    end
  end

  always_comb begin
    word_d = '0;
    word_d.divisor = mix_q.divisor;
    for (int k = 0; k < NumWheels; k++) begin
      prod[k]              = ProdW'(mix_q.mag[k]) * ProdW'(mix_q.peak);
      word_d.lane[k].neg   = mix_q.neg[k];
      word_d.lane[k].rem   = {1'b0, prod[k][ProdW-1:QuotW]};
      word_d.lane[k].low   = prod[k][QuotW-1:0];
    end
  end

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      mix_q <= mix_d;
    end
    if (b_ready && a_valid_q) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_word_o  = word_q;

endmodule

// ===== design/mwm_div_cell.sv =====
// Mecanum wheel mixer: one cell of the divider chain, one quotient bit for all
// four wheels per cell, registered. Depends on mwm_pkg.
module mwm_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mwm_pkg::mwm_word_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mwm_pkg::mwm_word_t out_word_o
);
  import mwm_pkg::*;

  logic [SumW:0] rem2 [NumWheels];
  logic [SumW:0] diff [NumWheels];
  logic          ge [NumWheels];
  mwm_word_t     word_d, word_q;
  logic          valid_q;

  always_comb begin
    word_d = in_word_i;
    for (int k = 0; k < NumWheels; k++) begin
      rem2[k] = {in_word_i.lane[k].rem, in_word_i.lane[k].low[QuotW-1]};
      diff[k] = rem2[k] - {1'b0, in_word_i.divisor};
      ge[k]   = rem2[k] >= {1'b0, in_word_i.divisor};
      word_d.lane[k].rem = ge[k] ? diff[k][SumW-1:0] : rem2[k][SumW-1:0];
      word_d.lane[k].low = {in_word_i.lane[k].low[QuotW-2:0], ge[k]};
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (word_q.lane[0].rem < word_q.divisor) && (word_q.lane[1].rem < word_q.divisor)
             && (word_q.lane[2].rem < word_q.divisor) && (word_q.lane[3].rem < word_q.divisor))
    else $error("remainder not below divisor");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> word_q.divisor != '0)
    else $error("zero divisor in chain");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(word_q))
    else $error("cell lost its beat under stall");

endmodule

// ===== design/mwm_out.sv =====
// Mecanum wheel mixer: clamp, sign and output register of the wheel speeds.
// Depends on mwm_pkg and mwm_wheel_if.
module mwm_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mwm_pkg::mwm_word_t in_word_i,
  mwm_wheel_if.source        wheel_o
);
  import mwm_pkg::*;

  logic [QuotW-1:0]         sat [NumWheels];
  logic signed [SpeedW-1:0] wheel_d [NumWheels];
  logic signed [SpeedW-1:0] wheel_q [NumWheels];
  logic                     valid_q;

  always_comb begin
    for (int k = 0; k < NumWheels; k++) begin
      sat[k] = (in_word_i.lane[k].low > WheelMax) ? WheelMax : in_word_i.lane[k].low;
      wheel_d[k] = in_word_i.lane[k].neg ? -signed'(sat[k]) : signed'(sat[k]);
    end
  end

  assign in_ready_o = !valid_q || wheel_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      wheel_q <= wheel_d;
    end
  end

  assign wheel_o.valid       = valid_q;
  assign wheel_o.wheel_one   = wheel_q[0];
  assign wheel_o.wheel_two   = wheel_q[1];
  assign wheel_o.wheel_three = wheel_q[2];
  assign wheel_o.wheel_four  = wheel_q[3];

  a_wheel_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (wheel_q[0] != 16'sh8000) && (wheel_q[1] != 16'sh8000)
             && (wheel_q[2] != 16'sh8000) && (wheel_q[3] != 16'sh8000))
    else $error("wheel speed outside clamp range");

endmodule

// ===== tb/mwm_wheel_checker.sv =====
// Scoreboard for the mecanum wheel mixer: predicts four wheel speeds per command beat
// and compares each wheel beat against the oldest prediction. Depends on mwm_pkg.
`timescale 1ns / 100ps

module mwm_wheel_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  logic                              cmd_ready_i,
  input  logic signed [mwm_pkg::SpeedW-1:0] strafe_i,
  input  logic signed [mwm_pkg::SpeedW-1:0] forward_i,
  input  logic signed [mwm_pkg::SpeedW-1:0] turn_i,
  input  logic                              wheel_valid_i,
  input  logic                              wheel_ready_i,
  input  logic signed [mwm_pkg::SpeedW-1:0] wheel_one_i,
  input  logic signed [mwm_pkg::SpeedW-1:0] wheel_two_i,
  input  logic signed [mwm_pkg::SpeedW-1:0] wheel_three_i,
  input  logic signed [mwm_pkg::SpeedW-1:0] wheel_four_i,
  output int                                errors_o,
  output int                                pending_o
);
  import mwm_pkg::*;

  typedef struct packed {
    logic signed [SpeedW-1:0] one;
    logic signed [SpeedW-1:0] two;
    logic signed [SpeedW-1:0] three;
    logic signed [SpeedW-1:0] four;
  } wheel_set_t;

  localparam longint WheelHi = longint'(WheelMax);
  localparam longint WheelLo = -longint'(WheelMax);

  wheel_set_t expected_wheels[$];
  int         err_count = 0;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [SpeedW-1:0] scale_wheel(longint combo, longint peak,
                                                           longint total);
    longint q;
    q = (combo * peak) / total;
    if (q > WheelHi) q = WheelHi;
    if (q < WheelLo) q = WheelLo;
    return q[SpeedW-1:0];
  endfunction

  function automatic wheel_set_t mix_wheels(logic signed [SpeedW-1:0] xs,
                                            logic signed [SpeedW-1:0] ys,
                                            logic signed [SpeedW-1:0] ws);
    longint     x, y, w, peak, total;
    wheel_set_t r;
    x     = xs;
    y     = ys;
    w     = ws;
    peak  = magnitude(y);
    if (magnitude(x) > peak) peak = magnitude(x);
    if (magnitude(w) > peak) peak = magnitude(w);
    total = magnitude(x) + magnitude(y) + magnitude(w);
    if (total == 0) total = 1;
    r.one   = scale_wheel(y - x + w, peak, total);
    r.two   = scale_wheel(y + x - w, peak, total);
    r.three = scale_wheel(y - x - w, peak, total);
    r.four  = scale_wheel(y + x + w, peak, total);
    return r;
  endfunction

  task automatic report(string msg);
    $display("%0t mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string field, logic signed [SpeedW-1:0] got,
                             logic signed [SpeedW-1:0] want);
    if (got !== want)
      report($sformatf("%s got %0d want %0d", field, got, want));
  endtask

  always @(posedge clk_i) begin
    wheel_set_t want;
    if (rst_ni) begin
      if (cmd_valid_i && cmd_ready_i)
        expected_wheels.push_back(mix_wheels(strafe_i, forward_i, turn_i));
      if (wheel_valid_i && wheel_ready_i) begin
        if (expected_wheels.size() == 0) begin
          report("wheel beat with no command outstanding");
        end else begin
          want = expected_wheels.pop_front();
          check_field("wheel_one", wheel_one_i, want.one);
          check_field("wheel_two", wheel_two_i, want.two);
          check_field("wheel_three", wheel_three_i, want.three);
          check_field("wheel_four", wheel_four_i, want.four);
        end
      end
      errors_o  <= err_count;
      pending_o <= expected_wheels.size();
    end
  end

endmodule

// ===== tb/mecanum_wheel_mixer_unit_tb.sv =====
// Top of the mecanum wheel mixer testbench: clock, reset, command and wheel-side traffic
// with random gaps, and the verdict. Depends on mwm_pkg, mwm_if and mwm_wheel_checker.
`timescale 1ns / 100ps

module mecanum_wheel_mixer_unit_tb;
  import mwm_pkg::*;

  localparam int RandomCmds = 550;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 40;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic burst;
  int   errors;
  int   pending;
  int   cycle_count = 0;

  mwm_cmd_if   cmd_bus();
  mwm_wheel_if wheel_bus();

  mecanum_wheel_mixer_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_bus),
    .wheel_o (wheel_bus)
  );

  mwm_wheel_checker checker_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_bus.valid),
    .cmd_ready_i   (cmd_bus.ready),
    .strafe_i      (cmd_bus.strafe_speed),
    .forward_i     (cmd_bus.forward_speed),
    .turn_i        (cmd_bus.turn_speed),
    .wheel_valid_i (wheel_bus.valid),
    .wheel_ready_i (wheel_bus.ready),
    .wheel_one_i   (wheel_bus.wheel_one),
    .wheel_two_i   (wheel_bus.wheel_two),
    .wheel_three_i (wheel_bus.wheel_three),
    .wheel_four_i  (wheel_bus.wheel_four),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic signed [SpeedW-1:0] random_speed();
    logic signed [SpeedW-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = '0;
      1:       v = 16'sd32767;
      2:       v = -16'sd32767;
      3:       v = 16'h8000;
      4:       v = SpeedW'($signed($urandom_range(0, 128)) - 64);
      default: v = SpeedW'($urandom());
    endcase
    return v;
  endfunction

  task automatic send_command(logic signed [SpeedW-1:0] x, logic signed [SpeedW-1:0] y,
                              logic signed [SpeedW-1:0] w);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid         <= 1'b1;
    cmd_bus.strafe_speed  <= x;
    cmd_bus.forward_speed <= y;
    cmd_bus.turn_speed    <= w;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // wheel side: random stall before each beat
  initial begin
    int stall;
    wheel_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        wheel_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      wheel_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!wheel_bus.valid) @(posedge clk_i);
    end
  end

  initial begin
    logic signed [SpeedW-1:0] x, y, w;
    rst_ni                = 1'b0;
    burst                 = 1'b0;
    cmd_bus.valid         <= 1'b0;
    cmd_bus.strafe_speed  <= '0;
    cmd_bus.forward_speed <= '0;
    cmd_bus.turn_speed    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero command, single axes, full-scale and out-of-range -32768, combined axes and +-1
    send_command(16'sd0, 16'sd0, 16'sd0);
    send_command(16'sd32767, 16'sd0, 16'sd0);
    send_command(16'sd0, 16'sd32767, 16'sd0);
    send_command(16'sd0, 16'sd0, 16'sd32767);
    send_command(-16'sd32767, 16'sd0, 16'sd0);
    send_command(16'sd0, -16'sd32767, 16'sd0);
    send_command(16'sd0, 16'sd0, -16'sd32767);
    send_command(16'h8000, 16'sd0, 16'sd0);
    send_command(16'sd0, 16'h8000, 16'sd0);
    send_command(16'sd0, 16'sd0, 16'h8000);
    send_command(16'sd32767, 16'sd32767, 16'sd32767);
    send_command(-16'sd32767, -16'sd32767, -16'sd32767);
    send_command(16'h8000, 16'h8000, 16'h8000);
    send_command(16'sd32767, -16'sd32767, 16'sd32767);
    send_command(16'h8000, 16'sd32767, 16'h8000);
    send_command(16'sd32767, 16'sd32767, 16'sd0);
    send_command(16'h8000, 16'h8000, 16'sd0);
    send_command(16'sd1, 16'sd0, 16'sd0);
    send_command(16'sd0, -16'sd1, 16'sd0);
    send_command(16'sd1, 16'sd1, 16'sd1);
    send_command(-16'sd1, -16'sd1, -16'sd1);
    send_command(16'sh5555, -16'sh2aab, 16'sh7fff);
    wait_drained();

    for (int i = 0; i < RandomCmds; i++) begin
      if (i % 60 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == RandomCmds / 2) wait_drained();
      x = random_speed();
      y = random_speed();
      w = random_speed();
      case ($urandom_range(0, 7))
        0:       x = '0;
        1:       y = '0;
        2:       w = '0;
        3: begin
          x = '0;
          w = '0;
        end
        default: ;
      endcase
      send_command(x, y, w);
    end
    burst = 1'b0;
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
